### src/mbs_pkg.sv
// shared constants and types for the multipart boundary scanner
`timescale 1ns / 1ps

package mbs_pkg;

    // boundary storage size in the register file
    localparam int MAX_BOUNDARY_BYTES_DEF = 32;
    localparam int BND_REG_BYTES          = 32;

    // widths of the configuration port
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 6;
    localparam int EFF_LEN_W  = 7;

    // register indexes (byte address is 8 * index)
    typedef enum logic [2:0] {
        REG_LEN        = 3'd0,
        REG_BND_LO     = 3'd1,
        REG_BND_MID_LO = 3'd2,
        REG_BND_MID_HI = 3'd3,
        REG_BND_HI     = 3'd4
    } t_reg_idx;

    // result event codes
    typedef enum logic [1:0] {
        EV_PART_START = 2'd0,
        EV_FINAL      = 2'd1,
        EV_NOT_FOUND  = 2'd2
    } t_event;

    localparam logic [7:0] CH_DASH = 8'h2d;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

endpackage

### src/multipart_boundary_scanner.sv
// multipart boundary scanner: sliding window boundary search over a byte stream
`timescale 1ns / 1ps

// Usage
//   input channel: one body byte per beat (i_data_byte) with i_last_byte on the
//   final byte of a buffer; accepted when i_valid is high and o_stall is low.
//   output channel: zero or one event per input byte (o_event_kind, o_part_offset),
//   taken when o_valid is high and i_stall is low.
//   configuration: APB-style port, boundary length at 0x00 and the four 64-bit
//   boundary byte words at 0x08..0x20; write only while the stream is idle.
// Timing
//   one byte per clock sustained while no stall holds the result register; the byte
//   is held in the input register, the window compare and phase update run between it
//   and the result register, so a result beat is offered from the result register.
//   the compare itself is a single 32-byte equality over the shifted window.
// Stalls
//   a stalled result holds the result register; the input register then stalls
//   the sender through o_stall while it holds a byte, so nothing is dropped.
// Reset
//   i_rst_n (synchronous, active low) empties both registers, sets the length
//   to 1, clears the boundary bytes and restarts scanning at offset zero.
//   a beat with i_last_byte also restarts the scan for the next buffer.
module multipart_boundary_scanner #(
    parameter int MAX_BOUNDARY_BYTES = mbs_pkg::MAX_BOUNDARY_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // byte input
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_last_byte,
    // event output
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_event_kind,
    output logic [31:0]                     o_part_offset,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mbs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [mbs_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [mbs_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int CNT_W = $clog2(MAX_BOUNDARY_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_BOUNDARY_BYTES);
    localparam logic [CNT_W-1:0] CNT_RESUME = CNT_W'((MAX_BOUNDARY_BYTES < 2) ?
                                                     MAX_BOUNDARY_BYTES : 2);
    localparam logic [mbs_pkg::EFF_LEN_W-1:0] LEN_MAX =
        mbs_pkg::EFF_LEN_W'(MAX_BOUNDARY_BYTES);

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_SUFFIX1,
        PH_SUFFIX2,
        PH_DONE
    } t_phase;

    // configuration registers
    logic [mbs_pkg::LEN_W-1:0]       r_len;
    logic [mbs_pkg::CFG_DATA_W-1:0]  r_bnd [4];

    // expected window contents and live lane mask, rebuilt from the registers
    logic [7:0]                      r_tgt  [MAX_BOUNDARY_BYTES];
    logic [MAX_BOUNDARY_BYTES-1:0]   r_mask;
    logic [7:0]                      n_tgt  [MAX_BOUNDARY_BYTES];
    logic [MAX_BOUNDARY_BYTES-1:0]   n_mask;

    // input register
    logic                            r_in_valid;
    logic [7:0]                      r_in_byte;
    logic                            r_in_last;

    // scan state
    logic [7:0]                      r_win [MAX_BOUNDARY_BYTES];
    logic [CNT_W-1:0]                r_cnt;
    t_phase                          r_phase;
    logic [7:0]                      r_fsb;
    logic [31:0]                     r_off;
    logic [31:0]                     r_bend;

    // result register
    logic                            r_out_valid;
    logic [1:0]                      r_out_kind;
    logic [31:0]                     r_out_off;

    // datapath
    logic                            cfg_wr;
    logic [2:0]                      cfg_idx;
    logic [mbs_pkg::EFF_LEN_W-1:0]   eff_len;
    logic                            out_free;
    logic                            proc;
    logic                            in_take;
    logic [MAX_BOUNDARY_BYTES-1:0]   lane_eq;
    logic                            win_hit;

    logic [CNT_W-1:0]                n_cnt;
    t_phase                          n_phase;
    logic [7:0]                      n_fsb;
    logic [31:0]                     n_bend;
    logic                            n_emit;
    logic [1:0]                      n_kind;
    logic [31:0]                     n_out_off;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];

    // handshake: the result register frees when empty or taken
    assign out_free = !r_out_valid || !i_stall;
    assign proc     = r_in_valid && out_free;
    assign in_take  = i_valid && !o_stall;
    assign o_stall  = r_in_valid && !out_free;

    assign o_valid       = r_out_valid;
    assign o_event_kind  = r_out_kind;
    assign o_part_offset = r_out_off;

    // length in use, clamped to the window depth
    assign eff_len = (mbs_pkg::EFF_LEN_W'(r_len) > LEN_MAX) ? LEN_MAX
                                                            : mbs_pkg::EFF_LEN_W'(r_len);

    always_comb begin
        unique case (cfg_idx)
            mbs_pkg::REG_LEN:        prdata = mbs_pkg::CFG_DATA_W'(r_len);
            mbs_pkg::REG_BND_LO:     prdata = r_bnd[0];
            mbs_pkg::REG_BND_MID_LO: prdata = r_bnd[1];
            mbs_pkg::REG_BND_MID_HI: prdata = r_bnd[2];
            mbs_pkg::REG_BND_HI:     prdata = r_bnd[3];
            default:                 prdata = '0;
        endcase
    end

    // window lane j holds the byte that must equal boundary byte len-1-j
    always_comb begin
        int         idx;
        logic [4:0] bsel;
        for (int j = 0; j < MAX_BOUNDARY_BYTES; j++) begin
            idx       = int'(eff_len) - 1 - j;
            bsel      = 5'(idx);
            n_mask[j] = (mbs_pkg::EFF_LEN_W'(j) < eff_len);
            n_tgt[j]  = 8'h00;
            if (idx >= 0 && idx < mbs_pkg::BND_REG_BYTES) begin
                n_tgt[j] = r_bnd[bsel[4:3]][{bsel[2:0], 3'b000} +: 8];
            end
        end
    end

    // compare the window as it stands after shifting in the new byte
    always_comb begin
        for (int j = 0; j < MAX_BOUNDARY_BYTES; j++) begin
            if (j == 0) begin
                lane_eq[j] = !r_mask[j] || (r_in_byte == r_tgt[j]);
            end else begin
                lane_eq[j] = !r_mask[j] || (r_win[j-1] == r_tgt[j]);
            end
        end
        win_hit = &lane_eq;
    end

    // phase update and event selection for the byte in the input register
    always_comb begin
        logic [CNT_W-1:0] cnt_inc;
        logic [31:0]      nxt;
        logic             hit_srch;

        cnt_inc  = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_W'(1);
        nxt      = r_off + 32'd1;
        hit_srch = win_hit && (eff_len != '0) &&
                   (mbs_pkg::EFF_LEN_W'(cnt_inc) >= eff_len);

        n_cnt     = cnt_inc;
        n_phase   = r_phase;
        n_fsb     = r_fsb;
        n_bend    = r_bend;
        n_emit    = 1'b0;
        n_kind    = mbs_pkg::EV_PART_START;
        n_out_off = nxt;

        unique case (r_phase)
            PH_SEARCH: begin
                if (hit_srch) begin
                    if (r_in_last) begin
                        n_emit = 1'b1;
                    end else begin
                        n_bend  = nxt;
                        n_phase = PH_SUFFIX1;
                    end
                end else if (r_in_last) begin
                    n_emit = 1'b1;
                    n_kind = mbs_pkg::EV_NOT_FOUND;
                end
            end
            PH_SUFFIX1: begin
                n_fsb = r_in_byte;
                if (r_in_last) begin
                    n_emit    = 1'b1;
                    n_out_off = r_bend;
                end else begin
                    n_phase = PH_SUFFIX2;
                end
            end
            PH_SUFFIX2: begin
                n_emit = 1'b1;
                if (r_fsb == mbs_pkg::CH_DASH && r_in_byte == mbs_pkg::CH_DASH) begin
                    n_kind  = mbs_pkg::EV_FINAL;
                    n_phase = PH_DONE;
                end else if (r_fsb == mbs_pkg::CH_CR && r_in_byte == mbs_pkg::CH_LF) begin
                    n_cnt   = '0;
                    n_phase = PH_SEARCH;
                end else begin
                    // no recognized suffix: rescan both bytes after the boundary
                    n_out_off = r_bend;
                    n_cnt     = CNT_RESUME;
                    if (eff_len == mbs_pkg::EFF_LEN_W'(1) && r_fsb == r_bnd[0][7:0]) begin
                        n_bend  = r_off;
                        n_fsb   = r_in_byte;
                        n_phase = PH_SUFFIX2;
                    end else if (eff_len != '0 && eff_len <= mbs_pkg::EFF_LEN_W'(2) &&
                                 win_hit) begin
                        n_bend  = nxt;
                        n_phase = PH_SUFFIX1;
                    end else begin
                        n_phase = PH_SEARCH;
                    end
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_SEARCH;
            end
        endcase

        // buffer end restarts the scan
        if (r_in_last) begin
            n_cnt   = '0;
            n_phase = PH_SEARCH;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt  <= n_tgt;
        r_mask <= n_mask;

        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end

        if (proc) begin
            r_win[0] <= r_in_byte;
            for (int j = 1; j < MAX_BOUNDARY_BYTES; j++) begin
                r_win[j] <= r_win[j-1];
            end
            r_fsb  <= n_fsb;
            r_bend <= n_bend;
        end

        if (proc && n_emit) begin
            r_out_kind <= n_kind;
            r_out_off  <= n_out_off;
        end

        if (!i_rst_n) begin
            r_len       <= mbs_pkg::LEN_RESET;
            r_bnd[0]    <= '0;
            r_bnd[1]    <= '0;
            r_bnd[2]    <= '0;
            r_bnd[3]    <= '0;
            r_in_valid  <= 1'b0;
            r_cnt       <= '0;
            r_phase     <= PH_SEARCH;
            r_off       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    mbs_pkg::REG_LEN:        r_len    <= pwdata[mbs_pkg::LEN_W-1:0];
                    mbs_pkg::REG_BND_LO:     r_bnd[0] <= pwdata;
                    mbs_pkg::REG_BND_MID_LO: r_bnd[1] <= pwdata;
                    mbs_pkg::REG_BND_MID_HI: r_bnd[2] <= pwdata;
                    mbs_pkg::REG_BND_HI:     r_bnd[3] <= pwdata;
                    default:                 r_len    <= r_len;
                endcase
            end

            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end

            if (proc) begin
                r_cnt   <= n_cnt;
                r_phase <= n_phase;
                r_off   <= r_in_last ? 32'd0 : r_off + 32'd1;
            end

            if (proc && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // no event code beyond not found ever leaves the block
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_kind == mbs_pkg::EV_PART_START ||
                         r_out_kind == mbs_pkg::EV_FINAL ||
                         r_out_kind == mbs_pkg::EV_NOT_FOUND))
        else $error("illegal event code on output");

    // a buffer end always restarts the scan at offset zero
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in_last |=> (r_phase == PH_SEARCH) && (r_off == 32'd0) && (r_cnt == '0))
        else $error("scan not restarted after buffer end");

    // bytes after the final boundary give no event
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && (r_phase == PH_DONE) |-> !n_emit)
        else $error("event produced after final boundary");

    // the resume counter never runs past the window depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("resume counter out of range");

    // a pending event is not overwritten while the receiver stalls
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |-> !proc)
        else $error("byte processed into a stalled result register");

endmodule

### test/multipart_boundary_scanner_chk.sv
// checker for the multipart boundary scanner: tracks config, predicts events, compares
`timescale 1ns / 1ps

module multipart_boundary_scanner_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [1:0]                     i_event_kind,
    input  logic [31:0]                    i_part_offset,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [mbs_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic [mbs_pkg::CFG_DATA_W-1:0] i_pwdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);

    localparam int MAX_BND = mbs_pkg::MAX_BOUNDARY_BYTES_DEF;

    typedef enum logic [1:0] {
        SCAN_SEARCH,
        SCAN_SUFFIX1,
        SCAN_SUFFIX2,
        SCAN_DONE
    } t_scan_phase;

    typedef struct packed {
        mbs_pkg::t_event kind;
        logic [31:0]     offset;
    } t_scan_evt;

    // register copies
    logic [mbs_pkg::LEN_W-1:0] cfg_len;
    logic [63:0]               cfg_bnd [4];

    // scan state, newest byte in win[0]
    logic [7:0]  win [MAX_BND];
    int          since_resume;
    t_scan_phase phase;
    logic [7:0]  suffix0;
    logic [31:0] offs;
    logic [31:0] bnd_end;

    t_scan_evt   pending_events [$];
    int          mismatches;
    int          events_checked;

    function automatic int eff_len();
        return (cfg_len > MAX_BND) ? MAX_BND : int'(cfg_len);
    endfunction

    function automatic logic [7:0] bnd_byte(int i);
        return cfg_bnd[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic bit window_hit(int n);
        if (n == 0 || since_resume < n)
            return 1'b0;
        for (int i = 0; i < n; i++)
            if (win[n - 1 - i] != bnd_byte(i))
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic clear_scan();
        for (int i = 0; i < MAX_BND; i++)
            win[i] = 8'h00;
        since_resume = 0;
        phase        = SCAN_SEARCH;
        suffix0      = 8'h00;
        offs         = 32'd0;
        bnd_end      = 32'd0;
    endtask

    task automatic expect_evt(mbs_pkg::t_event kind, logic [31:0] offset);
        t_scan_evt e;
        e.kind   = kind;
        e.offset = offset;
        pending_events.push_back(e);
    endtask

    // one body byte through the scanner
    task automatic scan_byte(logic [7:0] b, logic last);
        logic [31:0] pos;
        logic [31:0] nxt;
        int          n;
        pos = offs;
        nxt = offs + 32'd1;
        n   = eff_len();
        for (int i = MAX_BND - 1; i > 0; i--)
            win[i] = win[i - 1];
        win[0] = b;
        if (since_resume < MAX_BND)
            since_resume++;
        case (phase)
            SCAN_SEARCH: begin
                if (window_hit(n)) begin
                    if (last)
                        expect_evt(mbs_pkg::EV_PART_START, nxt);
                    else begin
                        bnd_end = nxt;
                        phase   = SCAN_SUFFIX1;
                    end
                end else if (last) begin
                    expect_evt(mbs_pkg::EV_NOT_FOUND, nxt);
                end
            end
            SCAN_SUFFIX1: begin
                suffix0 = b;
                if (last)
                    expect_evt(mbs_pkg::EV_PART_START, bnd_end);
                else
                    phase = SCAN_SUFFIX2;
            end
            SCAN_SUFFIX2: begin
                if (suffix0 == mbs_pkg::CH_DASH && b == mbs_pkg::CH_DASH) begin
                    expect_evt(mbs_pkg::EV_FINAL, nxt);
                    phase = SCAN_DONE;
                end else if (suffix0 == mbs_pkg::CH_CR && b == mbs_pkg::CH_LF) begin
                    expect_evt(mbs_pkg::EV_PART_START, nxt);
                    since_resume = 0;
                    phase        = SCAN_SEARCH;
                end else begin
                    expect_evt(mbs_pkg::EV_PART_START, bnd_end);
                    // both suffix bytes count again for the window
                    since_resume = 2;
                    if (n == 1 && suffix0 == bnd_byte(0)) begin
                        bnd_end = pos;
                        suffix0 = b;
                        phase   = SCAN_SUFFIX2;
                    end else if (n <= 2 && window_hit(n)) begin
                        bnd_end = nxt;
                        phase   = SCAN_SUFFIX1;
                    end else begin
                        phase = SCAN_SEARCH;
                    end
                end
            end
            default: ;
        endcase
        offs = nxt;
        if (last)
            clear_scan();
    endtask

    always @(posedge i_clk) begin
        t_scan_evt want;
        if (!i_rst_n) begin
            cfg_len = mbs_pkg::LEN_RESET;
            for (int k = 0; k < 4; k++)
                cfg_bnd[k] = 64'd0;
            clear_scan();
            pending_events.delete();
            mismatches     = 0;
            events_checked = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (mbs_pkg::t_reg_idx'(i_paddr[5:3]))
                    mbs_pkg::REG_LEN:        cfg_len    = i_pwdata[mbs_pkg::LEN_W-1:0];
                    mbs_pkg::REG_BND_LO:     cfg_bnd[0] = i_pwdata;
                    mbs_pkg::REG_BND_MID_LO: cfg_bnd[1] = i_pwdata;
                    mbs_pkg::REG_BND_MID_HI: cfg_bnd[2] = i_pwdata;
                    mbs_pkg::REG_BND_HI:     cfg_bnd[3] = i_pwdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                scan_byte(i_data_byte, i_last_byte);
            if (i_out_valid && !i_out_stall) begin
                if (pending_events.size() == 0) begin
                    $error("result beat with nothing expected: event_kind %0d part_offset %0d",
                           i_event_kind, i_part_offset);
                    mismatches++;
                end else begin
                    want = pending_events.pop_front();
                    if (i_event_kind !== want.kind) begin
                        $error("event_kind: expected %0d, got %0d", want.kind, i_event_kind);
                        mismatches++;
                    end
                    if (i_part_offset !== want.offset) begin
                        $error("part_offset: expected %0d, got %0d", want.offset, i_part_offset);
                        mismatches++;
                    end
                    events_checked++;
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_events.size();
        o_checked    <= events_checked;
    end

endmodule

### test/multipart_boundary_scanner_tb.sv
// testbench top for the multipart boundary scanner: stimulus, flow control and verdict
`timescale 1ns / 1ps

module multipart_boundary_scanner_tb;

    localparam int PHASES     = 10;   // boundary settings after the directed part
    localparam int PHASE_BYTES = 25;  // body bytes per setting, rounded up to whole buffers
    localparam int HOLD_CYCLES = 150; // long receiver hold-off
    localparam int SETTLE      = 4;   // cycles for a byte that makes no event to leave the block
    localparam int LIMIT       = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_body_beat;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;

    // byte channel
    logic                           byte_valid = 1'b0;
    logic                           byte_stall;
    logic [7:0]                     data_byte = 8'h00;
    logic                           last_byte = 1'b0;

    // event channel
    logic                           evt_valid;
    logic                           evt_stall = 1'b0;
    logic [1:0]                     event_kind;
    logic [31:0]                    part_offset;

    // register port
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [mbs_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [mbs_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [mbs_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    // checker feedback
    int                             fail_count;
    int                             pending;
    int                             checked;

    // flow control shared with the receiver process
    logic                           idle_on = 1'b1;
    int                             hold_req = 0;
    int                             holds_started = 0;
    int                             hold_left = 0;

    int                             cycles = 0;

    // stimulus state
    t_body_beat                     body_q [$];
    logic [7:0]                     bnd_bytes [32];
    int                             sz;          // boundary bytes that actually take part
    int                             bytes_sent = 0;
    int                             buffers_built = 0;

    multipart_boundary_scanner dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (byte_valid),
        .o_stall       (byte_stall),
        .i_data_byte   (data_byte),
        .i_last_byte   (last_byte),
        .o_valid       (evt_valid),
        .i_stall       (evt_stall),
        .o_event_kind  (event_kind),
        .o_part_offset (part_offset),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    multipart_boundary_scanner_chk chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (byte_valid),
        .i_in_stall    (byte_stall),
        .i_data_byte   (data_byte),
        .i_last_byte   (last_byte),
        .i_out_valid   (evt_valid),
        .i_out_stall   (evt_stall),
        .i_event_kind  (event_kind),
        .i_part_offset (part_offset),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit, generous against the slowest legal run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles, %0d events still expected", cycles, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when the stimulus asks for one;
    // the hold is counted here so the sender keeps offering bytes meanwhile
    always @(posedge clk) begin
        if (hold_left > 0) begin
            evt_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != holds_started) begin
            holds_started <= hold_req;
            hold_left     <= HOLD_CYCLES - 1;
            evt_stall     <= 1'b1;
        end else begin
            evt_stall <= idle_on && ($urandom_range(0, 99) < 32);
        end
    end

    // boundary-ish alphabet: the suffix characters, a few letters and anything
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return mbs_pkg::CH_DASH;
            1:       return mbs_pkg::CH_CR;
            2:       return mbs_pkg::CH_LF;
            3, 4:    return 8'h61 + 8'($urandom_range(0, 2));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_beat(logic [7:0] data, logic last);
        t_body_beat bt;
        bt.data = data;
        bt.last = last;
        body_q.push_back(bt);
    endtask

    task automatic add_noise(int n);
        repeat (n) add_beat(pick_byte(), 1'b0);
    endtask

    task automatic add_boundary(int n);
        for (int i = 0; i < n; i++)
            add_beat(bnd_bytes[i], 1'b0);
    endtask

    // one body buffer; mostly well-formed multipart bodies, the rest broken or noise
    task automatic build_buffer();
        int shape;
        int mark;
        shape = $urandom_range(0, 9);
        mark  = body_q.size();
        if (shape <= 5) begin
            // preamble, parts opened by boundary + CR LF, closing boundary + "--", epilogue
            add_noise($urandom_range(0, 3));
            repeat ($urandom_range(0, 2)) begin
                add_boundary(sz);
                add_beat(mbs_pkg::CH_CR, 1'b0);
                add_beat(mbs_pkg::CH_LF, 1'b0);
                add_noise($urandom_range(0, 4));
            end
            add_boundary(sz);
            add_beat(mbs_pkg::CH_DASH, 1'b0);
            add_beat(mbs_pkg::CH_DASH, 1'b0);
            add_noise($urandom_range(0, 2));
        end else if (shape == 6) begin
            // boundary with an arbitrary suffix
            add_boundary(sz);
            add_noise($urandom_range(1, 5));
        end else if (shape == 7) begin
            // boundary right at or one byte before the buffer end
            add_noise($urandom_range(0, 2));
            add_boundary(sz);
            add_noise($urandom_range(0, 1));
        end else if (shape == 8) begin
            // boundary cut one byte short
            add_boundary((sz > 0) ? sz - 1 : 0);
            add_noise($urandom_range(0, 3));
        end else begin
            add_noise($urandom_range(1, 6));
        end
        if (body_q.size() == mark)
            add_beat(pick_byte(), 1'b0);
        body_q[body_q.size() - 1].last = 1'b1;
        buffers_built++;
    endtask

    // offer every queued byte, idling at random between beats
    task automatic send_body();
        t_body_beat bt;
        while (body_q.size() > 0) begin
            bt = body_q.pop_front();
            while (idle_on && $urandom_range(0, 99) < 32) begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
            byte_valid <= 1'b1;
            data_byte  <= bt.data;
            last_byte  <= bt.last;
            @(posedge clk);
            while (byte_stall)
                @(posedge clk);
            bytes_sent++;
        end
        byte_valid <= 1'b0;
    endtask

    // setup phase, access phase until pready, then the port is released
    task automatic cfg_write(mbs_pkg::t_reg_idx idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every expected event is in, then let a silent byte clear the block
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // boundary for one setting: all-ones, zero length, lengths above the maximum,
    // the shortest lengths, all-zero bytes and random ones in between
    task automatic load_boundary(int ph);
        logic [mbs_pkg::LEN_W-1:0] len;
        logic [63:0]               word;
        case (ph)
            0:       len = 6'd32;
            1:       len = 6'd0;
            2:       len = 6'd63;
            3:       len = 6'd1;
            4:       len = 6'd2;
            6:       len = mbs_pkg::LEN_W'($urandom_range(33, 62));
            default: len = mbs_pkg::LEN_W'($urandom_range(1, 8));
        endcase
        for (int i = 0; i < 32; i++) begin
            if (ph == 0)
                bnd_bytes[i] = 8'hff;
            else if (ph == PHASES - 1)
                bnd_bytes[i] = 8'h00;
            else
                bnd_bytes[i] = pick_byte();
        end
        sz = (len > 32) ? 32 : int'(len);
        cfg_write(mbs_pkg::REG_LEN, 64'(len));
        for (int k = 0; k < 4; k++) begin
            for (int j = 0; j < 8; j++)
                word[j * 8 +: 8] = bnd_bytes[k * 8 + j];
            cfg_write(mbs_pkg::t_reg_idx'(k + 1), word);
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed buffers against the reset boundary (one byte, 0x00)
        for (int i = 0; i < 32; i++)
            bnd_bytes[i] = 8'h00;
        sz = 1;
        add_beat(8'h41, 1'b0);  // no boundary, ends on 0xff
        add_beat(8'hff, 1'b1);
        add_beat(8'h00, 1'b1);  // match on the last byte
        add_beat(8'h00, 1'b0);  // final boundary, byte after it is silent
        add_beat(mbs_pkg::CH_DASH, 1'b0);
        add_beat(mbs_pkg::CH_DASH, 1'b0);
        add_beat(8'h55, 1'b1);
        add_beat(8'h00, 1'b0);  // CR LF part start, then not found at the end
        add_beat(mbs_pkg::CH_CR, 1'b0);
        add_beat(mbs_pkg::CH_LF, 1'b0);
        add_beat(8'h12, 1'b1);
        add_beat(8'h00, 1'b0);  // only one suffix byte before the end
        add_beat(8'h7e, 1'b1);
        add_beat(8'h00, 1'b0);  // suffix byte is itself the boundary
        add_beat(8'h00, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(8'h33, 1'b1);
        add_beat(8'h00, 1'b0);  // second match lands on the buffer end
        add_beat(8'h41, 1'b0);
        add_beat(8'h00, 1'b1);
        buffers_built += 7;
        send_body();
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            // one setting runs with no idling on either side
            idle_on <= (ph != 5);
            load_boundary(ph);
            while (body_q.size() < PHASE_BYTES)
                build_buffer();
            // receiver holds off while the sender keeps going, so the block backs up
            if (ph == 3 || ph == 7)
                hold_req <= hold_req + 1;
            send_body();
            drain();
        end

        $display("scanned %0d body bytes in %0d buffers over %0d boundary settings",
                 bytes_sent, buffers_built, PHASES + 1);
        $display("%0d events compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
